// File: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define VWDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vwdb assertion failed");

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define VWDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vwdb assertion failed");

`endif

// File: design/vwdb_pkg.sv
// Package: payload types, controller/datapath link types and constants.
package vwdb_pkg;

    localparam int ENTRY_COUNT_DEF = 16;
    localparam int WEIGHT_W        = 32;
    localparam int RATE_W          = 15;
    localparam int DECAY_RATE_Q16  = 9830;
    localparam int DECAY_SHIFT     = 16;
    localparam int PROD_W          = WEIGHT_W + DECAY_SHIFT;

    localparam logic FUNC_INJECT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic                       func;
        logic [7:0]                 entry_index;
        logic signed [WEIGHT_W-1:0] amplitude;
        logic signed [WEIGHT_W-1:0] time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] total_weight;
        logic                       index_rejected;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic load_decay;  // register the decay step, clear the accumulator
        logic rd_en;       // read both stores at rd_addr
        logic wb_en;       // update and write back the entry read last cycle
        logic commit_sum;  // last write-back: latch the new total
        logic load_out;    // load the output register
    } vwdb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
    } vwdb_status_t;

endpackage

// File: design/vwdb_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface vwdb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/vwdb_ctrl.sv
// Controller: sequences inject and tick transactions over the entry bank.
module vwdb_ctrl #(
    parameter int ENTRY_COUNT = vwdb_pkg::ENTRY_COUNT_DEF,
    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1,
    localparam int CNT_W = $clog2(ENTRY_COUNT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_func,
    input  vwdb_pkg::vwdb_status_t status,
    output logic                 in_ready,
    output vwdb_pkg::vwdb_cmd_t  cmd,
    output logic [IDX_W-1:0]     rd_addr
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECAY  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } vwdb_state_t;

    vwdb_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             walk_last;

    assign walk_last = (cnt_reg == CNT_W'(ENTRY_COUNT));
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = (in_func == vwdb_pkg::FUNC_TICK) ? ST_DECAY : ST_FINISH;
                    cnt_next   = '0;
                end
            end
            ST_DECAY:
            begin
                cmd.load_decay = 1'b1;
                cmd.rd_en      = 1'b1;
                cnt_next       = cnt_reg + CNT_W'(1);
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.wb_en = 1'b1;
                if (walk_last)
                begin
                    cmd.commit_sum = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/vwdb_datapath.sv
// Datapath: weight stores, decay multiplier, follower update and output register.
module vwdb_datapath #(
    parameter int ENTRY_COUNT = vwdb_pkg::ENTRY_COUNT_DEF,
    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vwdb_pkg::in_item_t     in_item,
    input  vwdb_pkg::vwdb_cmd_t    cmd,
    input  logic [IDX_W-1:0]       rd_addr,
    input  logic                   out_ready,
    output vwdb_pkg::vwdb_status_t status,
    output logic                   out_valid,
    output vwdb_pkg::out_item_t    out_item
);

    localparam int W = vwdb_pkg::WEIGHT_W;
    localparam int P = vwdb_pkg::PROD_W;

    // Stores; an entry never written since reset reads as zero.
    logic [W-1:0]           cur_mem [ENTRY_COUNT];
    logic [W-1:0]           tgt_mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] cur_vld_reg;
    logic [ENTRY_COUNT-1:0] tgt_vld_reg;

    logic [W-1:0]     cur_rd_reg, tgt_rd_reg;
    logic             cur_rd_vld_reg, tgt_rd_vld_reg;
    logic [IDX_W-1:0] wb_addr_reg;

    logic signed [W-1:0] dt_reg;
    logic signed [W-1:0] decay_reg;
    logic                rej_reg;
    logic [W-1:0]        sum_acc_reg;
    logic [W-1:0]        weight_sum_reg;
    logic                out_valid_reg;
    vwdb_pkg::out_item_t out_item_reg;

    logic                in_range;
    logic                inject_we;
    logic [IDX_W-1:0]    tgt_waddr;
    logic [W-1:0]        tgt_wdata;
    logic                tgt_we;
    logic signed [P-1:0] decay_prod;
    logic [W-1:0]        cur_val, tgt_val, diff, half, cur_new, tgt_new, sum_next;

    assign in_range  = ({1'b0, in_item.entry_index} < 9'(ENTRY_COUNT));
    assign inject_we = cmd.accept && (in_item.func == vwdb_pkg::FUNC_INJECT) && in_range;

    // floor(rate * dt / 2^16): arithmetic shift of the full product
    assign decay_prod = P'(dt_reg) * P'($signed(vwdb_pkg::RATE_W'(vwdb_pkg::DECAY_RATE_Q16)));

    assign cur_val  = cur_rd_vld_reg ? cur_rd_reg : '0;
    assign tgt_val  = tgt_rd_vld_reg ? tgt_rd_reg : '0;
    assign diff     = tgt_val - cur_val;
    assign half     = {diff[W-1], diff[W-1:1]};
    assign cur_new  = cur_val + half;
    assign tgt_new  = ($signed(tgt_val) > decay_reg) ? (tgt_val - W'(decay_reg)) : '0;
    assign sum_next = sum_acc_reg + cur_new;

    assign tgt_we    = inject_we || cmd.wb_en;
    assign tgt_waddr = inject_we ? in_item.entry_index[IDX_W-1:0] : wb_addr_reg;
    assign tgt_wdata = inject_we ? W'(in_item.amplitude) : tgt_new;

    // Memory ports: one read, one write per store.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            cur_rd_reg  <= cur_mem[rd_addr];
            tgt_rd_reg  <= tgt_mem[rd_addr];
            wb_addr_reg <= rd_addr;
        end
        if (cmd.wb_en)
        begin
            cur_mem[wb_addr_reg] <= cur_new;
        end
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg    <= '0;
            tgt_vld_reg    <= '0;
            cur_rd_vld_reg <= 1'b0;
            tgt_rd_vld_reg <= 1'b0;
            weight_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                cur_rd_vld_reg <= cur_vld_reg[rd_addr];
                tgt_rd_vld_reg <= tgt_vld_reg[rd_addr];
            end
            if (cmd.wb_en)
            begin
                cur_vld_reg[wb_addr_reg] <= 1'b1;
            end
            if (tgt_we)
            begin
                tgt_vld_reg[tgt_waddr] <= 1'b1;
            end
            if (cmd.commit_sum)
            begin
                weight_sum_reg <= sum_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dt_reg  <= in_item.time_step;
            rej_reg <= (in_item.func == vwdb_pkg::FUNC_INJECT) && !in_range;
        end
        if (cmd.load_decay)
        begin
            decay_reg   <= decay_prod[P-1:vwdb_pkg::DECAY_SHIFT];
            sum_acc_reg <= '0;
        end
        else if (cmd.wb_en)
        begin
            sum_acc_reg <= sum_next;
        end
        if (cmd.load_out)
        begin
            out_item_reg.total_weight   <= cmd.commit_sum ? sum_next : weight_sum_reg;
            out_item_reg.index_rejected <= rej_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

// File: design/viseme_weight_decay_bank.sv
// Top level: bank of Q16.16 envelope followers with valid/ready request and response.
//
// A bank of ENTRY_COUNT envelope followers, one per mouth shape, each holding a
// current and a target weight in Q16.16. Every request transaction yields exactly
// one response transaction. An inject (func 0) writes one target weight; an index
// at or above ENTRY_COUNT writes nothing and the response flags index_rejected.
// A tick (func 1) registers a decay step of floor(9830 * time_step / 2^16), then
// walks the bank one entry per cycle: the current weight moves half way to its
// target (arithmetic shift), the target drops by the decay step and clamps at zero,
// and the new current weights are summed. All arithmetic wraps at 32 bits. The
// response carries the total after the last tick. An inject goes from acceptance
// straight to the result hand-off; a tick registers the decay step and then walks
// the bank one entry per cycle, set by the single read and write port of each
// weight store. A request is taken whenever the bank is idle, even while the
// previous response still waits in the output register. The stores need no
// clearing pass after reset: per-entry valid bits make unwritten entries read as
// zero, so the block is ready in the first cycle after reset.
`include "assert_macros.svh"

module viseme_weight_decay_bank #(
    parameter int ENTRY_COUNT = vwdb_pkg::ENTRY_COUNT_DEF,
    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input logic         clk,
    input logic         rst_n,
    vwdb_stream_if.sink   request,
    vwdb_stream_if.source response
);

    vwdb_pkg::vwdb_cmd_t    cmd;
    vwdb_pkg::vwdb_status_t status;
    vwdb_pkg::in_item_t     in_item;
    logic [IDX_W-1:0]       rd_addr;
    logic                   in_ready;

    // Pull the request fields into the package type.
    always_comb
    begin
        in_item.func        = request.payload.func;
        in_item.entry_index = request.payload.entry_index;
        in_item.amplitude   = request.payload.amplitude;
        in_item.time_step   = request.payload.time_step;
    end

    assign request.ready = in_ready;

    // Sequencer: idle, decay setup, entry walk, result hand-off.
    vwdb_ctrl #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_func  (request.payload.func),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // Stores, arithmetic and the output register.
    vwdb_datapath #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .out_ready (response.ready),
        .status    (status),
        .out_valid (response.valid),
        .out_item  (response.payload)
    );

    // Never write back an entry while a new transaction may be taken.
    `VWDB_ASSERT_NOW(a_no_walk_when_idle, in_ready, !cmd.wb_en)
    // Load the output register only when it has room.
    `VWDB_ASSERT_NOW(a_load_needs_room, cmd.load_out, status.out_free)
    // A tick keeps the bank busy for the cycle after acceptance.
    `VWDB_ASSERT_NEXT(a_tick_holds_busy, cmd.accept && (request.payload.func == vwdb_pkg::FUNC_TICK), !in_ready && cmd.load_decay)
    // The last write-back is followed by the hand-off, not a new transaction.
    `VWDB_ASSERT_NEXT(a_commit_then_finish, cmd.commit_sum, !in_ready && !cmd.wb_en)

endmodule

// File: bench/vwdb_bank_checker.sv
// Checker for the weight decay bank: predicts each response and compares it.
`timescale 1ns / 1ps

module vwdb_bank_checker #(
    parameter int BANK_SIZE = vwdb_pkg::ENTRY_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  vwdb_pkg::in_item_t  req_item,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  vwdb_pkg::out_item_t rsp_item,
    output int unsigned         fail_count,
    output int unsigned         pending
);

    localparam int W = vwdb_pkg::WEIGHT_W;
    localparam int P = vwdb_pkg::PROD_W;
    localparam logic signed [P-1:0] RATE = P'(vwdb_pkg::DECAY_RATE_Q16);

    logic [W-1:0]        cur_w [BANK_SIZE];
    logic [W-1:0]        tgt_w [BANK_SIZE];
    logic [W-1:0]        sum_w;
    vwdb_pkg::out_item_t expected_totals [$];
    int unsigned         errs;

    // Floor of rate * dt / 2^16; the product fits in P bits.
    function automatic logic signed [W-1:0] decay_step(input logic signed [W-1:0] dt);
        logic signed [P-1:0] dt_ext;
        logic signed [P-1:0] product;
        dt_ext  = dt;
        product = dt_ext * RATE;
        return product[P-1:vwdb_pkg::DECAY_SHIFT];
    endfunction

    // Apply one request to the bank copy and return the response it earns.
    task automatic advance_bank(input vwdb_pkg::in_item_t it, output vwdb_pkg::out_item_t res);
        logic signed [W-1:0] decay;
        logic signed [W-1:0] half;
        logic [W-1:0]        diff;
        logic [W-1:0]        acc;
        res.index_rejected = 1'b0;
        if (it.func == vwdb_pkg::FUNC_INJECT) begin
            if (it.entry_index < BANK_SIZE)
                tgt_w[it.entry_index] = it.amplitude;
            else
                res.index_rejected = 1'b1;
        end else begin
            decay = decay_step(it.time_step);
            acc   = '0;
            for (int i = 0; i < BANK_SIZE; i++) begin
                diff     = tgt_w[i] - cur_w[i];
                half     = $signed(diff) >>> 1;
                cur_w[i] = cur_w[i] + half;
                if ($signed(tgt_w[i]) > decay)
                    tgt_w[i] = tgt_w[i] - decay;
                else
                    tgt_w[i] = '0;
                acc = acc + cur_w[i];
            end
            sum_w = acc;
        end
        res.total_weight = sum_w;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vwdb_pkg::out_item_t want;
        vwdb_pkg::out_item_t got;
        if (!rst_n) begin
            for (int i = 0; i < BANK_SIZE; i++) begin
                cur_w[i] = '0;
                tgt_w[i] = '0;
            end
            sum_w = '0;
            expected_totals.delete();
            errs = 0;
        end else begin
            // Retire the response first: it can never belong to a request taken this edge.
            if (rsp_valid && rsp_ready) begin
                got = rsp_item;
                if (expected_totals.size() == 0) begin
                    errs++;
                    $display("%0t: response with none expected: total %h rejected %b",
                             $time, got.total_weight, got.index_rejected);
                end else begin
                    want = expected_totals.pop_front();
                    if (got.total_weight !== want.total_weight) begin
                        errs++;
                        $display("%0t: total_weight expected %h actual %h",
                                 $time, want.total_weight, got.total_weight);
                    end
                    if (got.index_rejected !== want.index_rejected) begin
                        errs++;
                        $display("%0t: index_rejected expected %b actual %b",
                                 $time, want.index_rejected, got.index_rejected);
                    end
                end
            end
            if (req_valid && req_ready) begin
                advance_bank(req_item, want);
                expected_totals.push_back(want);
            end
        end
        fail_count <= errs;
        pending    <= expected_totals.size();
    end

endmodule

// File: bench/tb_top.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int          RANDOM_PER_PHASE = 150;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int          DRAIN_CYCLES     = 40;
    localparam int          BANK_SIZE        = vwdb_pkg::ENTRY_COUNT_DEF;

    logic        clk;
    logic        rst_n;
    logic        quiet;          // set to suppress idling on both sides
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count;

    vwdb_stream_if #(.payload_t(vwdb_pkg::in_item_t))  req_if ();
    vwdb_stream_if #(.payload_t(vwdb_pkg::out_item_t)) rsp_if ();

    viseme_weight_decay_bank u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    vwdb_bank_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_if.valid),
        .req_ready  (req_if.ready),
        .req_item   (req_if.payload),
        .rsp_valid  (rsp_if.valid),
        .rsp_ready  (rsp_if.ready),
        .rsp_item   (rsp_if.payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Build an inject; the time step is ignored, so fill it with noise.
    function automatic vwdb_pkg::in_item_t inject_cmd(input logic [7:0] idx,
                                                      input logic [31:0] amp);
        vwdb_pkg::in_item_t it;
        it.func        = vwdb_pkg::FUNC_INJECT;
        it.entry_index = idx;
        it.amplitude   = amp;
        it.time_step   = $urandom;
        return it;
    endfunction

    // Build a tick; index and amplitude are ignored, so fill them with noise.
    function automatic vwdb_pkg::in_item_t tick_cmd(input logic [31:0] dt);
        vwdb_pkg::in_item_t it;
        it.func        = vwdb_pkg::FUNC_TICK;
        it.entry_index = 8'($urandom);
        it.amplitude   = $urandom;
        it.time_step   = dt;
        return it;
    endfunction

    // Mostly small Q16.16 values of either sign, sometimes any 32-bit pattern.
    function automatic logic [31:0] random_weight();
        if ($urandom_range(0, 9) < 3)
            return $urandom;
        return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endfunction

    // Mostly a frame-sized positive step; now and then negative or anything at all.
    function automatic logic [31:0] random_step();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            return -32'($urandom_range(0, 32'h0002_0000));
        return 32'($urandom_range(0, 32'h0002_0000));
    endfunction

    function automatic vwdb_pkg::in_item_t random_cmd();
        logic [7:0] idx;
        if ($urandom_range(0, 9) < 3)
            return tick_cmd(random_step());
        // Keep most injects in range so that the bank fills up; the rest get rejected.
        if ($urandom_range(0, 9) < 8)
            idx = 8'($urandom_range(0, BANK_SIZE - 1));
        else
            idx = 8'($urandom_range(BANK_SIZE, 255));
        return inject_cmd(idx, random_weight());
    endfunction

    // Present one transaction after a random gap and hold it until it is taken.
    task automatic send_request(input vwdb_pkg::in_item_t it);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Drop valid and hold off until the checker has every response back.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Response side: stall a random number of cycles before taking each transaction.
    initial
    begin
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        quiet          = 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a tick on an empty bank, range edges of every field,
        // rejected indexes, zero, negative and extreme time steps.
        send_request(tick_cmd(32'h0000_0000));
        send_request(inject_cmd(8'd0, 32'h7FFF_FFFF));
        send_request(inject_cmd(8'(BANK_SIZE - 1), 32'h8000_0000));
        send_request(inject_cmd(8'(BANK_SIZE), 32'h1234_5678));
        send_request(inject_cmd(8'd255, 32'hFFFF_FFFF));
        send_request(inject_cmd(8'd7, 32'hFFFF_FFFF));
        send_request(inject_cmd(8'd3, 32'h0001_0000));
        send_request(tick_cmd(32'h0000_0000));
        send_request(tick_cmd(32'h0000_4444));
        send_request(tick_cmd(32'hFFFF_FFFF));
        send_request(tick_cmd(32'hFFFF_0000));
        send_request(inject_cmd(8'd8, 32'h0000_0000));
        send_request(inject_cmd(8'd9, 32'h0002_8000));
        send_request(tick_cmd(32'h7FFF_FFFF));
        send_request(inject_cmd(8'd1, 32'h7FFF_FFFF));
        send_request(inject_cmd(8'd2, 32'h8000_0001));
        send_request(tick_cmd(32'h8000_0000));
        send_request(tick_cmd(32'h0001_0000));
        send_request(inject_cmd(8'd128, 32'h0000_0001));
        send_request(tick_cmd(32'h0000_0001));

        // Hold off the sender until the bank has answered everything.
        drain_responses();

        // Random part in three phases; the middle one runs without idling.
        for (int phase = 0; phase < 3; phase++) begin
            quiet = (phase == 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_cmd());
            drain_responses();
        end

        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
